// ----- sv/ieps_pkg.sv -----
// Shared types, codes and tables of the I2C EEPROM page sequencer.
package ieps_pkg;

   localparam int PAGE_BYTES  = 8;
   localparam int MAX_RESULTS = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RIDX_W      = $clog2(MAX_RESULTS);

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_POLL   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_RESTART   = 3'd1;
   localparam logic [2:0] OP_STOP      = 3'd2;
   localparam logic [2:0] OP_WRITE     = 3'd3;
   localparam logic [2:0] OP_READ_ACK  = 3'd4;
   localparam logic [2:0] OP_READ_NACK = 3'd5;
   localparam logic [2:0] OP_REJECT    = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] address;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       acked;
      logic       collision;
   } req_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] bus_byte;
      logic       poll_wait;
      logic       run_end;
   } rsp_type;

   // One queued job: the full list of primitives caused by one item.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][2:0] op;
      logic [MAX_RESULTS-1:0][7:0] bus_byte;
      logic [RIDX_W-1:0]           last_idx;
      logic                        poll_wait;
   } job_type;

   typedef logic [7:0] page_table_type [256];

   // Bytes left in the page that holds each address, counting that address.
   function automatic page_table_type page_left_table();
      page_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'(PAGE_BYTES - (i % PAGE_BYTES));
      end
      return t;
   endfunction

   localparam page_table_type PAGE_LEFT = page_left_table();

endpackage

// ----- sv/ieps_front.sv -----
// Front end: accepts items, tracks transfer state and builds primitive lists.
module ieps_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  ieps_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output ieps_pkg::job_type push_job
);

   logic [6:0] dev_ff;
   logic [7:0] cur_ff, cur_in;
   logic [7:0] page_ff, page_in;
   logic       hdr_ff, hdr_in;
   logic       await_ff, await_in;
   logic       done_ff, done_in;

   logic [7:0]  ctrl_w;
   logic [7:0]  cur_v;
   logic [7:0]  page_v;
   logic [7:0]  page_dec;
   logic        open_hdr;
   logic        close_page;
   logic [2:0]  n;
   ieps_pkg::job_type job;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign push_job  = job;
   assign ctrl_w    = {dev_ff, 1'b0};

   always_comb begin
      cur_in   = cur_ff;
      page_in  = page_ff;
      hdr_in   = hdr_ff;
      await_in = await_ff;
      done_in  = done_ff;
      job      = '0;
      n        = 3'd0;
      cur_v    = req_data.first ? req_data.address : cur_ff;
      open_hdr = 1'b0;
      page_v   = page_ff;
      page_dec = page_ff;
      close_page = 1'b0;

      if (req_data.kind == ieps_pkg::KIND_UNUSED ||
          ((req_data.kind == ieps_pkg::KIND_POLL) != await_ff)) begin
         job.op[n] = ieps_pkg::OP_REJECT;
         n = n + 3'd1;
      end else if (req_data.kind == ieps_pkg::KIND_POLL) begin
         if (req_data.acked && !req_data.collision) begin
            job.op[n] = ieps_pkg::OP_STOP;
            n = n + 3'd1;
            await_in = 1'b0;
         end else begin
            job.op[n] = ieps_pkg::OP_START;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = ctrl_w;
            n = n + 3'd1;
            await_in = 1'b1;
         end
      end else if (req_data.kind == ieps_pkg::KIND_WRITE) begin
         open_hdr = req_data.first || hdr_ff;
         page_v   = open_hdr ? ieps_pkg::PAGE_LEFT[cur_v] : page_ff;
         page_dec = (page_v != 8'd0) ? page_v - 8'd1 : 8'd0;
         close_page = (page_dec == 8'd0) || req_data.last;
         if (open_hdr) begin
            job.op[n] = ieps_pkg::OP_START;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = ctrl_w;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = cur_v;
            n = n + 3'd1;
         end
         job.op[n] = ieps_pkg::OP_WRITE;
         job.bus_byte[n] = req_data.data;
         n = n + 3'd1;
         cur_in  = cur_v + 8'd1;
         page_in = page_dec;
         hdr_in  = 1'b0;
         done_in = 1'b0;
         if (close_page) begin
            // The page closes and the first acknowledge poll goes out at once.
            job.op[n] = ieps_pkg::OP_STOP;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_START;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = ctrl_w;
            n = n + 3'd1;
            hdr_in   = 1'b1;
            await_in = 1'b1;
            done_in  = req_data.last;
         end
      end else begin
         if (req_data.first || done_ff) begin
            job.op[n] = ieps_pkg::OP_START;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = ctrl_w;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = cur_v;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_RESTART;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_WRITE;
            job.bus_byte[n] = {dev_ff, 1'b1};
            n = n + 3'd1;
         end
         cur_in = cur_v + 8'd1;
         hdr_in = 1'b1;
         if (req_data.last) begin
            job.op[n] = ieps_pkg::OP_READ_NACK;
            n = n + 3'd1;
            job.op[n] = ieps_pkg::OP_STOP;
            n = n + 3'd1;
            done_in = 1'b1;
         end else begin
            job.op[n] = ieps_pkg::OP_READ_ACK;
            n = n + 3'd1;
            done_in = 1'b0;
         end
      end

      job.last_idx  = ieps_pkg::RIDX_W'(n - 3'd1);
      job.poll_wait = await_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff   <= ieps_pkg::DEVICE_ADDRESS_RESET;
         cur_ff   <= 8'd0;
         page_ff  <= 8'd0;
         hdr_ff   <= 1'b1;
         await_ff <= 1'b0;
         done_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            dev_ff <= csr_wr_data;
         end
         if (push) begin
            cur_ff   <= cur_in;
            page_ff  <= page_in;
            hdr_ff   <= hdr_in;
            await_ff <= await_in;
            done_ff  <= done_in;
         end
      end
   end

endmodule

// ----- sv/ieps_queue.sv -----
// Short job queue between the front end and the bus sequencer.
module ieps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ieps_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ieps_pkg::job_type head
);

   ieps_pkg::job_type                store_ff [ieps_pkg::QUEUE_DEPTH];
   logic [ieps_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ieps_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ieps_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = (count_ff == ieps_pkg::QCNT_W'(ieps_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ieps_pkg::QPTR_W'(ieps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ieps_pkg::QPTR_W'(ieps_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- sv/ieps_back.sv -----
// Back end: walks the head job and sends one bus primitive per transfer.
module ieps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  ieps_pkg::job_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ieps_pkg::rsp_type rsp_data
);

   logic [ieps_pkg::RIDX_W-1:0] idx_ff, idx_in;
   logic                        at_end;
   logic                        moved;

   assign at_end    = (idx_ff == head.last_idx);
   assign rsp_valid = !empty;
   assign moved     = rsp_valid && !rsp_stall;
   assign pop       = moved && at_end;

   assign rsp_data.op        = head.op[idx_ff];
   assign rsp_data.bus_byte  = head.bus_byte[idx_ff];
   assign rsp_data.poll_wait = head.poll_wait;
   assign rsp_data.run_end   = at_end;

   always_comb begin
      idx_in = idx_ff;
      if (moved) begin
         idx_in = at_end ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- sv/i2c_eeprom_page_sequencer.sv -----
// The first primitive of an item is offered in the cycle after its transfer
// when the job queue is empty and the bus sequencer is idle.
// An item gives one to seven primitives, one per cycle on rsp while rsp_stall is low;
// the bus sequencer walks a job list one entry a cycle unless stalled, and a two-entry
// job queue lets input run ahead.
// Reset: synchronous; clears the queue and the transfer state, device address 80.
module i2c_eeprom_page_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  ieps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ieps_pkg::rsp_type rsp_data
);

   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   ieps_pkg::job_type push_job;
   ieps_pkg::job_type head;

   ieps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   ieps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   ieps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
